// ----- hdl/tga_uncompressed_rgb_stream_parser_top_macros.svh -----
`ifndef TGA_UNCOMPRESSED_RGB_STREAM_PARSER_TOP_MACROS_SVH
`define TGA_UNCOMPRESSED_RGB_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define TGAP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TGAP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tgap_pkg.sv -----
`timescale 1ns / 1ps
package tgap_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes, in header order
  localparam logic [3:0] ERR_ID_LEN     = 4'd0;
  localparam logic [3:0] ERR_CMAP_TYPE  = 4'd1;
  localparam logic [3:0] ERR_IMG_TYPE   = 4'd2;
  localparam logic [3:0] ERR_CMAP_ORG   = 4'd3;
  localparam logic [3:0] ERR_CMAP_DEPTH = 4'd4;
  localparam logic [3:0] ERR_X_ORG      = 4'd5;
  localparam logic [3:0] ERR_Y_ORG      = 4'd6;
  localparam logic [3:0] ERR_WIDTH      = 4'd7;
  localparam logic [3:0] ERR_HEIGHT     = 4'd8;
  localparam logic [3:0] ERR_BPP        = 4'd9;
  localparam logic [3:0] ERR_DESC       = 4'd10;

  // header byte offsets that finish a field
  localparam logic [4:0] HB_ID_LEN      = 5'd0;
  localparam logic [4:0] HB_CMAP_TYPE   = 5'd1;
  localparam logic [4:0] HB_IMG_TYPE    = 5'd2;
  localparam logic [4:0] HB_CMAP_ORG    = 5'd4;
  localparam logic [4:0] HB_CMAP_LEN    = 5'd6;
  localparam logic [4:0] HB_CMAP_DEPTH  = 5'd7;
  localparam logic [4:0] HB_X_ORG       = 5'd9;
  localparam logic [4:0] HB_Y_ORG       = 5'd11;
  localparam logic [4:0] HB_WIDTH       = 5'd13;
  localparam logic [4:0] HB_HEIGHT      = 5'd15;
  localparam logic [4:0] HB_BPP         = 5'd16;
  localparam logic [4:0] HB_DESC        = 5'd17;
  localparam logic [4:0] HB_LAST        = 5'd17;

  localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] BPP_24             = 8'd24;

  localparam int EXT_W  = 15;
  localparam int AREA_W = 30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [3:0]       error_code;
    logic [EXT_W-1:0] image_width;
    logic [EXT_W-1:0] image_height;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
  } result_t;

endpackage

// ----- hdl/tgap_in_if.sv -----
`timescale 1ns / 1ps
interface tgap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_file;

  modport source (output valid, output data_byte, output start_file, input ready);
  modport sink (input valid, input data_byte, input start_file, output ready);
endinterface

// ----- hdl/tgap_out_if.sv -----
`timescale 1ns / 1ps
interface tgap_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  error_code;
  logic [14:0] image_width;
  logic [14:0] image_height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;

  modport source (
    output valid, output result_kind, output error_code, output image_width,
    output image_height, output red, output green, output blue, output last_pixel,
    input ready
  );
  modport sink (
    input valid, input result_kind, input error_code, input image_width,
    input image_height, input red, input green, input blue, input last_pixel,
    output ready
  );
endinterface

// ----- hdl/tga_uncompressed_rgb_stream_parser_top.sv -----
`timescale 1ns / 1ps
// Streaming parser for uncompressed 24-bit truecolor TGA files, one file byte per item
// with start_file marking byte 0. The block sustains one item per cycle while out_ch is
// not stalled: each byte is parsed in a single step between the input register and the
// result register, so a byte is held in the input register and its result is then
// registered in the result register that drives out_ch. The header's last byte emits
// width and height (the pixel count is formed by one 15x15 multiply in that step), a
// failed header check emits one error item and the block then waits for the next start
// flag, and every B,G,R triple of the image after a good header emits one pixel item.
`include "tga_uncompressed_rgb_stream_parser_top_macros.svh"
module tga_uncompressed_rgb_stream_parser_top
  import tgap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tgap_in_if.sink     in_ch,
  tgap_out_if.source  out_ch
);

  logic     held;
  in_item_t item;
  logic     take;
  logic     res_push;
  result_t  res;
  logic     out_space;

  tgap_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .held  (held),
    .item  (item)
  );

  tgap_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .item      (item),
    .out_space (out_space),
    .take      (take),
    .res_push  (res_push),
    .res       (res)
  );

  tgap_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .res    (res),
    .space  (out_space),
    .out_ch (out_ch)
  );

  `TGAP_ASSERT_NXT(a_held_item_kept, held && !take, held, "stalled item dropped from input register")
  `TGAP_ASSERT_IMP(a_push_has_room, res_push, out_space, "result pushed into a full output register")
  `TGAP_ASSERT_IMP(a_hdr_extent, out_ch.valid && out_ch.result_kind == KIND_HEADER, out_ch.image_width != '0 && out_ch.image_height != '0, "header result with zero extent")
  `TGAP_ASSERT_IMP(a_err_fields_clear, out_ch.valid && out_ch.result_kind == KIND_ERROR, out_ch.image_width == '0 && out_ch.red == '0 && out_ch.last_pixel == 1'b0, "error result carries stray fields")

endmodule

// ----- hdl/tgap_in_reg.sv -----
`timescale 1ns / 1ps
module tgap_in_reg
  import tgap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tgap_in_if.sink     in_ch,
  input  logic        take,
  output logic        held,
  output in_item_t    item
);

  logic     held_r, held_nxt;
  in_item_t item_r, item_nxt;
  logic     load;

  assign in_ch.ready = !held_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    held_nxt = held_r;
    item_nxt = item_r;
    if (load) begin
      held_nxt = 1'b1;
      item_nxt = '{data_byte: in_ch.data_byte, start_file: in_ch.start_file};
    end else if (take) begin
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign held = held_r;
  assign item = item_r;

endmodule

// ----- hdl/tgap_core.sv -----
`timescale 1ns / 1ps
module tgap_core
  import tgap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     held,
  input  in_item_t item,
  input  logic     out_space,
  output logic     take,
  output logic     res_push,
  output result_t  res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [EXT_W-1:0]  width_r, width_nxt;
  logic [EXT_W-1:0]  height_r, height_nxt;
  logic [AREA_W-1:0] left_r, left_nxt;
  logic [1:0]        tri_r, tri_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        green_r, green_nxt;

  logic [1:0]        phase_eff;
  logic [4:0]        idx_eff;
  logic [AREA_W-1:0] left_eff;
  logic [AREA_W-1:0] left_dec;
  logic [1:0]        tri_eff;
  logic [7:0]        d;
  logic [15:0]       word;
  logic              word_bad_ext;
  logic [AREA_W-1:0] area;
  logic              err_hit;
  logic [3:0]        err_code;
  logic              has_res;

  assign d            = item.data_byte;
  assign word         = {d, low_r};
  assign word_bad_ext = (word == 16'd0) || word[15];
  assign area         = {{(AREA_W-EXT_W){1'b0}}, width_r} * {{(AREA_W-EXT_W){1'b0}}, height_r};

  // start flag abandons the current file
  assign phase_eff = item.start_file ? PH_HEADER : phase_r;
  assign idx_eff   = item.start_file ? 5'd0 : idx_r;
  assign tri_eff   = item.start_file ? 2'd0 : tri_r;
  assign left_eff  = item.start_file ? '0 : left_r;
  assign left_dec  = left_eff - AREA_W'(1);

  always_comb begin
    phase_nxt  = phase_eff;
    idx_nxt    = idx_eff;
    low_nxt    = low_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    left_nxt   = left_eff;
    tri_nxt    = tri_eff;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    err_hit    = 1'b0;
    err_code   = ERR_ID_LEN;
    has_res    = 1'b0;
    res        = '0;

    case (phase_eff)
      PH_HEADER: begin
        case (idx_eff)
          HB_ID_LEN: begin
            err_hit = (d != 8'd0);
            err_code = ERR_ID_LEN;
          end
          HB_CMAP_TYPE: begin
            err_hit = (d != 8'd0);
            err_code = ERR_CMAP_TYPE;
          end
          HB_IMG_TYPE: begin
            err_hit = (d != IMG_TYPE_TRUECOLOR);
            err_code = ERR_IMG_TYPE;
          end
          HB_CMAP_ORG: begin
            err_hit = (word != 16'd0);
            err_code = ERR_CMAP_ORG;
          end
          HB_CMAP_LEN: begin
            // length is not checked; drop the high byte
          end
          HB_CMAP_DEPTH: begin
            err_hit = (d != 8'd0);
            err_code = ERR_CMAP_DEPTH;
          end
          HB_X_ORG: begin
            err_hit = (word != 16'd0);
            err_code = ERR_X_ORG;
          end
          HB_Y_ORG: begin
            err_hit = (word != 16'd0);
            err_code = ERR_Y_ORG;
          end
          HB_WIDTH: begin
            width_nxt = word[EXT_W-1:0];
            err_hit = word_bad_ext;
            err_code = ERR_WIDTH;
          end
          HB_HEIGHT: begin
            height_nxt = word[EXT_W-1:0];
            err_hit = word_bad_ext;
            err_code = ERR_HEIGHT;
          end
          HB_BPP: begin
            err_hit = (d != BPP_24);
            err_code = ERR_BPP;
          end
          HB_DESC: begin
            err_hit = (d != 8'd0);
            err_code = ERR_DESC;
          end
          default: begin
            low_nxt = d;
          end
        endcase

        if (err_hit) begin
          phase_nxt       = PH_IDLE;
          idx_nxt         = 5'd0;
          has_res         = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code  = err_code;
        end else if (idx_eff >= HB_LAST) begin
          phase_nxt        = PH_PIXELS;
          idx_nxt          = 5'd0;
          tri_nxt          = 2'd0;
          left_nxt         = area;
          has_res          = 1'b1;
          res.result_kind  = KIND_HEADER;
          res.image_width  = width_r;
          res.image_height = height_r;
        end else begin
          idx_nxt = idx_eff + 5'd1;
        end
      end
      PH_PIXELS: begin
        case (tri_eff)
          2'd0: begin
            blue_nxt = d;
            tri_nxt  = 2'd1;
          end
          2'd1: begin
            green_nxt = d;
            tri_nxt   = 2'd2;
          end
          default: begin
            tri_nxt         = 2'd0;
            left_nxt        = left_dec;
            has_res         = 1'b1;
            res.result_kind = KIND_PIXEL;
            res.red         = d;
            res.green       = green_r;
            res.blue        = blue_r;
            if (left_dec == '0) begin
              res.last_pixel = 1'b1;
              phase_nxt      = PH_IDLE;
            end
          end
        endcase
      end
      default: begin
        // idle: ignore the byte
      end
    endcase
  end

  // items with no result never wait for the output register
  assign take     = held && (out_space || !has_res);
  assign res_push = take && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      idx_r    <= 5'd0;
      low_r    <= 8'd0;
      width_r  <= '0;
      height_r <= '0;
      left_r   <= '0;
      tri_r    <= 2'd0;
      blue_r   <= 8'd0;
      green_r  <= 8'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      low_r    <= low_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      left_r   <= left_nxt;
      tri_r    <= tri_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule

// ----- hdl/tgap_out_reg.sv -----
`timescale 1ns / 1ps
module tgap_out_reg
  import tgap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   res,
  output logic      space,
  tgap_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (push) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.result_kind  = res_r.result_kind;
  assign out_ch.error_code   = res_r.error_code;
  assign out_ch.image_width  = res_r.image_width;
  assign out_ch.image_height = res_r.image_height;
  assign out_ch.red          = res_r.red;
  assign out_ch.green        = res_r.green;
  assign out_ch.blue         = res_r.blue;
  assign out_ch.last_pixel   = res_r.last_pixel;

endmodule
